/* rtl/aed_pkg.sv */
// shared constants, register codes and controller command type for the echo delay line
package aed_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int DELAY_W   = 17;
    localparam int DIV_W     = 16;
    localparam int MAX_DELAY = 65536;
    localparam int ADDR_W    = $clog2(MAX_DELAY);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CMP_W     = (CNT_W > DELAY_W) ? CNT_W : DELAY_W;
    localparam int STEP_W    = $clog2(DIV_W);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(8000);
    localparam logic [DIV_W-1:0]   VOL_RST   = DIV_W'(4);

    localparam logic FUNC_MIX  = 1'b0;
    localparam logic FUNC_TAIL = 1'b1;

    localparam logic REG_DELAY_LENGTH   = 1'b0;
    localparam logic REG_VOLUME_DIVISOR = 1'b1;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

endpackage

/* rtl/aed_ram.sv */
// generic single-write, single-read ram with registered read data
module aed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/aed_ctrl.sv */
// controller: sequences read, divide and write-back for one beat at a time
module aed_ctrl
    import aed_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

    t_state              r_state;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_m_tvalid;
    logic                w_out_free;

    assign w_out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.rd     = (r_state == S_READ);
        o_cmd.load   = (r_state == S_LOAD);
        o_cmd.step   = (r_state == S_DIV);
        o_cmd.finish = (r_state == S_DONE) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_m_tvalid <= o_cmd.finish || (r_m_tvalid && !i_m_tready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + STEP_W'(1);
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;

`ifndef NO_ASSERTIONS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_READ))
        else $error("accepted beat did not start a read");

    a_div_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == LAST_STEP) |=> (r_state == S_DONE))
        else $error("divide did not end after its last step");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_m_tvalid)
        else $error("finished beat not presented");
`endif

endmodule

/* rtl/aed_dp.sv */
// datapath: delay memory, ring index, restoring divider and mixer
module aed_dp
    import aed_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_func,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [DELAY_W-1:0]  i_delay_length,
    input  logic [DIV_W-1:0]    i_volume_divisor,
    output logic [SAMPLE_W-1:0] o_sample
);

    logic [ADDR_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_hw;
    logic                r_func;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_echo;
    logic                r_neg;
    logic [SAMPLE_W-1:0] r_q;
    logic [DIV_W-1:0]    r_rem;
    logic [DIV_W-1:0]    r_div;
    logic [SAMPLE_W-1:0] r_out;

    logic [SAMPLE_W-1:0] w_rdata;
    logic [SAMPLE_W-1:0] w_echo;
    logic [DIV_W:0]      w_shift;
    logic                w_fit;
    logic [SAMPLE_W-1:0] w_qs;
    logic [CMP_W-1:0]    w_len;
    logic [CNT_W-1:0]    w_next;
    logic [SAMPLE_W-1:0] w_wdata;

    aed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.finish),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // entries at or above the high-water mark were never written and read as zero
    assign w_echo = (CNT_W'(r_idx) < r_hw) ? w_rdata : '0;

    always_comb begin
        if (i_delay_length == '0) begin
            w_len = CMP_W'(1);
        end else if (CMP_W'(i_delay_length) > CMP_W'(MAX_DELAY)) begin
            w_len = CMP_W'(MAX_DELAY);
        end else begin
            w_len = CMP_W'(i_delay_length);
        end
    end

    assign w_next  = CNT_W'(r_idx) + CNT_W'(1);
    assign w_shift = {r_rem, r_q[SAMPLE_W-1]};
    assign w_fit   = (w_shift >= {1'b0, r_div});
    assign w_qs    = r_neg ? (SAMPLE_W'(0) - r_q) : r_q;
    // tail beats write back what they read so the written set stays a prefix
    assign w_wdata = (r_func == FUNC_MIX) ? r_sample : r_echo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_hw  <= '0;
        end else if (i_cmd.finish) begin
            if (CMP_W'(w_next) >= w_len) begin
                r_idx <= '0;
            end else begin
                r_idx <= w_next[ADDR_W-1:0];
            end
            if (w_next > r_hw) begin
                r_hw <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= i_func;
            r_sample <= i_sample;
        end
        if (i_cmd.load) begin
            r_echo <= w_echo;
            r_neg  <= w_echo[SAMPLE_W-1];
            r_q    <= w_echo[SAMPLE_W-1] ? (SAMPLE_W'(0) - w_echo) : w_echo;
            r_rem  <= '0;
            r_div  <= (i_volume_divisor == '0) ? DIV_W'(1) : i_volume_divisor;
        end
        if (i_cmd.step) begin
            r_q <= {r_q[SAMPLE_W-2:0], w_fit};
            if (w_fit) begin
                r_rem <= DIV_W'(w_shift - {1'b0, r_div});
            end else begin
                r_rem <= w_shift[DIV_W-1:0];
            end
        end
        if (i_cmd.finish) begin
            r_out <= (r_func == FUNC_TAIL) ? w_qs : (r_sample + w_qs);
        end
    end

    assign o_sample = r_out;

`ifndef NO_ASSERTIONS
    a_idx_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (CMP_W'(r_idx) < $past(w_len)))
        else $error("ring index left the ring");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_hw) <= CMP_W'(MAX_DELAY))
        else $error("high-water mark beyond memory depth");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> (r_rem < r_div))
        else $error("divider remainder not reduced");
`endif

endmodule

/* rtl/audio_echo_delay_line.sv */
// top level: single-tap audio echo with circular delay memory and apb registers
//
// channel   dir   handshake                      payload
// s_axis    in    s_axis_tvalid/s_axis_tready    tdata: sample_in, tuser: func
// m_axis    out   m_axis_tvalid/m_axis_tready    tdata: sample_out
// apb       in    psel/penable/pwrite, pready=1  delay_length @0, volume_divisor @4
//
// one beat at a time: memory read, then a 16-step restoring divider
// the result sits in an output register, so a new beat is taken while it waits
// reset needs no clearing pass: a high-water mark makes unwritten entries read as zero
// a stalled output holds the finished beat until the previous one is taken
module audio_echo_delay_line
    import aed_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [SAMPLE_W-1:0] s_axis_tdata,   // [15:0] sample_in
    input  logic                s_axis_tuser,   // [0] func
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SAMPLE_W-1:0] m_axis_tdata,   // [15:0] sample_out
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [DELAY_W-1:0] r_delay_length;
    logic [DIV_W-1:0]   r_volume_divisor;
    t_cmd               w_cmd;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length   <= DELAY_RST;
            r_volume_divisor <= VOL_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_DELAY_LENGTH:   r_delay_length   <= pwdata[DELAY_W-1:0];
                REG_VOLUME_DIVISOR: r_volume_divisor <= pwdata[DIV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DELAY_LENGTH:   prdata = PDATA_W'(r_delay_length);
            REG_VOLUME_DIVISOR: prdata = PDATA_W'(r_volume_divisor);
            default:            prdata = '0;
        endcase
    end

    aed_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    aed_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_func           (s_axis_tuser),
        .i_sample         (s_axis_tdata),
        .i_delay_length   (r_delay_length),
        .i_volume_divisor (r_volume_divisor),
        .o_sample         (m_axis_tdata)
    );

endmodule

/* tb/testbench.sv */
// testbench for audio_echo_delay_line: ring-buffer echo predictor, stream driver and monitor
`timescale 1ns / 1ps

module testbench;
    import aed_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SINK_HOLD    = 400;
    localparam int SETTLE       = 40;
    localparam int RANDOM_BEATS = 1550;

    typedef struct packed {
        logic                func;
        logic [SAMPLE_W-1:0] smp;
    } t_echo_beat;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [SAMPLE_W-1:0] s_axis_tdata = '0;   // [15:0] sample_in
    logic                s_axis_tuser = 1'b0; // [0] func
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [SAMPLE_W-1:0] m_axis_tdata;        // [15:0] sample_out
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // predictor state
    logic [SAMPLE_W-1:0] echo_mem [MAX_DELAY];
    int unsigned         ring_pos;
    logic [DELAY_W-1:0]  delay_len;
    logic [DIV_W-1:0]    vol_div;

    t_echo_beat          pending_beats [$];
    logic [SAMPLE_W-1:0] expected_samples [$];
    t_echo_beat          next_beat;
    logic [SAMPLE_W-1:0] want;
    int                  errors = 0;
    int                  cycles = 0;
    int                  src_idle_pct = 0;
    int                  sink_stall_pct = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    audio_echo_delay_line DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic int ring_length(logic [DELAY_W-1:0] n);
        if (n == 0) return 1;
        if (n > MAX_DELAY) return MAX_DELAY;
        return int'(n);
    endfunction

    // mixed or tail sample for one beat; updates the ring on mix beats and the index on every beat
    function automatic logic [SAMPLE_W-1:0] mix_echo(logic func, logic [SAMPLE_W-1:0] smp);
        int unsigned         idx;
        int                  div;
        int                  echo;
        logic [SAMPLE_W-1:0] res;
        idx  = (ring_pos >= MAX_DELAY) ? 0 : ring_pos;
        div  = (vol_div == 0) ? 1 : int'(vol_div);
        echo = int'($signed(echo_mem[idx])) / div;
        if (func == FUNC_MIX) begin
            res = SAMPLE_W'(int'($signed(smp)) + echo);
            echo_mem[idx] = smp;
        end else begin
            res = SAMPLE_W'(echo);
        end
        ring_pos = (idx + 1 >= ring_length(delay_len)) ? 0 : idx + 1;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'h0001;
            5: return SAMPLE_W'($urandom_range(255)) - 16'd128;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // stream driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_samples.push_back(mix_echo(s_axis_tuser, s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_beat.func;
                    s_axis_tdata  <= next_beat.smp;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t sample_out: expected none, actual %h", $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t sample_out: expected %h, actual %h",
                                 $time, want, m_axis_tdata);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = SINK_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic reg_write(logic code, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] exp_val;
        if (code == REG_DELAY_LENGTH)
            exp_val = PDATA_W'(value[DELAY_W-1:0]);
        else
            exp_val = PDATA_W'(value[DIV_W-1:0]);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(code) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (pready && prdata !== exp_val) begin
            $display("%0t prdata: expected %h, actual %h", $time, exp_val, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (code == REG_DELAY_LENGTH)
            delay_len = DELAY_W'(value);
        else
            vol_div = DIV_W'(value);
    endtask

    task automatic queue_beat(logic func, logic [SAMPLE_W-1:0] smp);
        pending_beats.push_back('{func: func, smp: smp});
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_samples.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        int                 phase;
        int                 rand_beats;
        int                 len;
        int                 burst;
        int                 phase_beats;
        logic [DELAY_W-1:0] dly;
        logic [DIV_W-1:0]   div;

        foreach (echo_mem[i]) echo_mem[i] = '0;
        ring_pos  = 0;
        delay_len = DELAY_RST;
        vol_div   = VOL_RST;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: echo still silent
        queue_beat(FUNC_MIX, 16'h7FFF);
        queue_beat(FUNC_MIX, 16'h8000);
        queue_beat(FUNC_MIX, 16'h0000);
        queue_beat(FUNC_MIX, 16'hFFFF);
        queue_beat(FUNC_TAIL, 16'hFFFF);
        wait_drained();

        // zero delay acts as one, full-level echo, sum wraps
        reg_write(REG_DELAY_LENGTH, 0);
        reg_write(REG_VOLUME_DIVISOR, 1);
        @(negedge i_clk);
        queue_beat(FUNC_MIX, 16'h7FFF);
        queue_beat(FUNC_MIX, 16'h7FFF);
        queue_beat(FUNC_MIX, 16'h8000);
        queue_beat(FUNC_MIX, 16'h8000);
        queue_beat(FUNC_TAIL, 16'h0000);
        wait_drained();

        // zero divisor
        reg_write(REG_VOLUME_DIVISOR, 0);
        @(negedge i_clk);
        queue_beat(FUNC_MIX, 16'h1234);
        queue_beat(FUNC_MIX, 16'h8000);
        queue_beat(FUNC_TAIL, 16'h5555);
        wait_drained();

        // largest divisor, then the delay shrinks below the index
        reg_write(REG_DELAY_LENGTH, 10);
        reg_write(REG_VOLUME_DIVISOR, 32'h0000_FFFF);
        @(negedge i_clk);
        for (int i = 0; i < 6; i++) queue_beat(FUNC_MIX, i[0] ? 16'h8000 : 16'hFFF9);
        wait_drained();
        reg_write(REG_DELAY_LENGTH, 3);
        reg_write(REG_VOLUME_DIVISOR, 2);
        @(negedge i_clk);
        queue_beat(FUNC_MIX, 16'hFFF9);
        queue_beat(FUNC_MIX, 16'h0007);
        queue_beat(FUNC_MIX, 16'h8001);
        queue_beat(FUNC_TAIL, 16'h0000);
        wait_drained();

        rand_beats = 0;
        phase = 0;
        while (rand_beats < RANDOM_BEATS) begin
            case ($urandom_range(9))
                0: dly = DELAY_W'(1);
                1: dly = '0;
                2: dly = DELAY_W'(MAX_DELAY);
                3: dly = '1;
                4: dly = DELAY_W'($urandom_range(2, 8));
                default: dly = DELAY_W'($urandom_range(2, 48));
            endcase
            case ($urandom_range(9))
                0: div = '0;
                1: div = DIV_W'(1);
                2: div = 16'hFFFF;
                3: div = 16'h8000;
                4: div = DIV_W'($urandom_range(2, 16));
                5: div = DIV_W'($urandom_range(1, 65535));
                default: div = DIV_W'($urandom_range(1, 8));
            endcase
            reg_write(REG_DELAY_LENGTH, PDATA_W'(dly));
            reg_write(REG_VOLUME_DIVISOR, PDATA_W'(div));
            @(negedge i_clk);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
                default: begin src_idle_pct = 37; sink_stall_pct = 37; end
            endcase
            len = ring_length(dly);
            phase_beats = 0;
            if (len > 64) begin
                // long rings: short burst only, tails read whatever is stored
                for (int i = 0; i < 40; i++) begin
                    queue_beat($urandom_range(4) == 0 ? FUNC_TAIL : FUNC_MIX, pick_sample());
                    phase_beats++;
                end
            end else begin
                while (phase_beats < 120) begin
                    burst = $urandom_range(1, 3 * len);
                    for (int i = 0; i < burst; i++) queue_beat(FUNC_MIX, pick_sample());
                    phase_beats += burst;
                    case ($urandom_range(9))
                        0: burst = $urandom_range(0, len);
                        1: burst = 0;
                        default: burst = len;
                    endcase
                    for (int i = 0; i < burst; i++) queue_beat(FUNC_TAIL, pick_sample());
                    phase_beats += burst;
                    if ($urandom_range(4) == 0) begin
                        for (int i = 0; i < 6; i++)
                            queue_beat(1'($urandom_range(1)), pick_sample());
                        phase_beats += 6;
                    end
                end
            end
            // long receiver hold-off while the sender keeps offering
            if (phase == 4 || phase == 12) hold_req++;
            rand_beats += phase_beats;
            wait_drained();
            phase++;
        end

        if (errors == 0 && expected_samples.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/aed_pkg.sv
rtl/aed_ram.sv
rtl/aed_ctrl.sv
rtl/aed_dp.sv
rtl/audio_echo_delay_line.sv
tb/testbench.sv
